FILE: rtl/sample_scope_plotter_macros.svh
// Assertion macros used by the sample scope plotter plotting engine (ssp_back).
`ifndef SAMPLE_SCOPE_PLOTTER_MACROS_SVH
`define SAMPLE_SCOPE_PLOTTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SSP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ssp_pkg.sv
// Types and constants shared by the sample scope plotter modules.
`default_nettype none

package ssp_pkg;

  typedef enum logic [1:0] {
    ACT_BEGIN = 2'd0,
    ACT_PLOT  = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_t;

  localparam logic [1:0] ST_CONTINUE = 2'd0;
  localparam logic [1:0] ST_STOPPED  = 2'd1;
  localparam logic [1:0] ST_DONE     = 2'd2;

  localparam logic REG_MAIN_VOLUME  = 1'b0;
  localparam logic REG_SCOPE_HEIGHT = 1'b1;

  localparam int IN_DATA_W  = 80;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 32;
  localparam int RES_W      = 28;

  // The queue depth must be a power of two so that the pointers wrap freely.
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [6:0] SVOL_MAX = 7'd127;

  typedef enum logic [2:0] {
    B_IDLE,
    B_MUL2,
    B_ROW,
    B_WRITE,
    B_CLEAR,
    B_READ
  } back_state_t;

  typedef struct packed {
    action_t            kind;
    logic [8:0]         x_start;
    logic [8:0]         column_count;
    logic [6:0]         scaled_volume;
    logic [15:0]        sample_words;
    logic               short_sample;
    logic [15:0]        repeat_words;
    logic signed [7:0]  sample_value;
    logic [11:0]        read_index;
  } cmd_t;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        next_in_loop;
    logic [16:0] next_offset;
    logic [1:0]  status;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/sample_scope_plotter.sv
// Top level of the sample scope plotter: configuration registers and stream ports.
//
// Input words arrive on the s_ group; s_tuser carries the action (begin, plot,
// clear, read) and s_tdata the begin, plot and read fields. Every accepted word
// produces exactly one result word on the m_ group, in order. main_volume and
// scope_height are written through cfg_we, cfg_index and cfg_data; the user must
// write them only while idle, which the block itself does not enforce.
// A word passes an input register and a four-entry queue before the plotting
// engine takes it, and a read passes the registered plane read besides.
// The engine works on one word at a time: begin is done at dispatch, read goes
// through a registered plane read, plot through two registered multiplies, row
// saturation, then a bit-masked write into the plane, and clear sweeps every
// plane byte in turn after its dispatch.
// After reset the plane is zeroed by the same sweep, during which s_tready
// stays low; configuration writes are taken as ever.
// When the receiver stalls, the result waits in the output register, the
// engine holds, the queue fills and s_tready drops once the queue and input
// register are full.
`default_nettype none

module sample_scope_plotter #(
  parameter int PLANE_WIDTH  = 320,
  parameter int PLANE_HEIGHT = 64
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  // Fields from bit 0: x_start, column_count, channel_volume, sample_words,
  // repeat_words, sample_value, read_index, zero fill.
  input  wire logic [ssp_pkg::IN_DATA_W-1:0]   s_tdata,
  // Fields from bit 0: action.
  input  wire logic [ssp_pkg::IN_USER_W-1:0]   s_tuser,
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  // Fields from bit 0: status, next_offset, next_in_loop, read_data, zero fill.
  output logic [ssp_pkg::OUT_DATA_W-1:0]       m_tdata,
  input  wire logic                            cfg_we,
  input  wire logic                            cfg_index,
  input  wire logic [6:0]                      cfg_data
);

  logic [6:0]    main_volume;
  logic [5:0]    scope_height;
  logic          boot;
  logic          q_full;
  logic          q_push;
  ssp_pkg::cmd_t q_data;
  logic          q_pop;
  ssp_pkg::cmd_t q_head;
  logic          q_valid;
  ssp_pkg::res_t result;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_volume  <= 7'd64;
      scope_height <= 6'd32;
    end else if (cfg_we) begin
      case (cfg_index)
        ssp_pkg::REG_MAIN_VOLUME:  main_volume  <= cfg_data;
        ssp_pkg::REG_SCOPE_HEIGHT: scope_height <= cfg_data[5:0];
        default:                   main_volume  <= main_volume;
      endcase
    end
  end

  ssp_front u_front (
    .clk         (clk),
    .rst         (rst),
    .hold        (boot),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_data     (s_tdata),
    .in_user     (s_tuser),
    .main_volume (main_volume),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_data)
  );

  ssp_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_data),
    .full      (q_full),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_valid)
  );

  ssp_back #(
    .PLANE_WIDTH  (PLANE_WIDTH),
    .PLANE_HEIGHT (PLANE_HEIGHT)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .head         (q_head),
    .q_valid      (q_valid),
    .pop          (q_pop),
    .scope_height (scope_height),
    .boot         (boot),
    .out_valid    (m_tvalid),
    .out_ready    (m_tready),
    .out_data     (result)
  );

  assign m_tdata = {(ssp_pkg::OUT_DATA_W - ssp_pkg::RES_W)'(0), result};

endmodule

`default_nettype wire

FILE: rtl/ssp_front.sv
// Front end: accepts input words, decodes them and hands commands to the queue.
`default_nettype none

module ssp_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           hold,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [ssp_pkg::IN_DATA_W-1:0]  in_data,
  input  wire logic [ssp_pkg::IN_USER_W-1:0]  in_user,
  input  wire logic [6:0]                     main_volume,
  input  wire logic                           q_full,
  output logic                                q_push,
  output ssp_pkg::cmd_t                       q_data
);

  logic          f_valid;
  ssp_pkg::cmd_t f_data;
  ssp_pkg::cmd_t decoded;
  logic [13:0]   vol_prod;
  logic [7:0]    vol_shift;
  logic          accept;

  assign q_push   = f_valid && !q_full;
  assign in_ready = !hold && (!f_valid || !q_full);
  assign accept   = in_valid && in_ready;
  assign q_data   = f_data;

  always_comb begin
    vol_prod  = in_data[24:18] * main_volume;
    vol_shift = vol_prod[13:6];
    decoded.kind          = ssp_pkg::action_t'(in_user);
    decoded.x_start       = in_data[8:0];
    decoded.column_count  = in_data[17:9];
    decoded.scaled_volume = (vol_shift > {1'b0, ssp_pkg::SVOL_MAX}) ?
                            ssp_pkg::SVOL_MAX : vol_shift[6:0];
    decoded.sample_words  = in_data[40:25];
    decoded.short_sample  = (in_data[40:25] < 16'd2);
    decoded.repeat_words  = in_data[56:41];
    decoded.sample_value  = $signed(in_data[64:57]);
    decoded.read_index    = in_data[76:65];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (accept) begin
      f_valid <= 1'b1;
    end else if (q_push) begin
      f_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f_data <= decoded;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ssp_queue.sv
// Short command queue between the front end and the plotting engine.
`default_nettype none

module ssp_queue (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  input  wire ssp_pkg::cmd_t push_data,
  output logic               full,
  input  wire logic          pop,
  output ssp_pkg::cmd_t      head,
  output logic               not_empty
);

  ssp_pkg::cmd_t                 entries [ssp_pkg::QUEUE_DEPTH];
  logic [ssp_pkg::QPTR_W-1:0]    wr_ptr;
  logic [ssp_pkg::QPTR_W-1:0]    rd_ptr;
  logic [ssp_pkg::QPTR_W:0]      count;
  logic                          do_push;
  logic                          do_pop;

  assign full      = (count == (ssp_pkg::QPTR_W + 1)'(ssp_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ssp_back.sv
// Plotting engine: channel state, sample scaling, bitplane memory and result register.
`default_nettype none
`include "sample_scope_plotter_macros.svh"

module ssp_back #(
  parameter int PLANE_WIDTH  = 320,
  parameter int PLANE_HEIGHT = 64
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire ssp_pkg::cmd_t head,
  input  wire logic          q_valid,
  output logic               pop,
  input  wire logic [5:0]    scope_height,
  output logic               boot,
  output logic               out_valid,
  input  wire logic          out_ready,
  output ssp_pkg::res_t      out_data
);

  localparam int ROW_BYTES = (PLANE_WIDTH + 7) / 8;
  localparam int DEPTH     = ROW_BYTES * PLANE_HEIGHT;
  localparam int AW        = $clog2(DEPTH);
  localparam int ROW_W     = (PLANE_HEIGHT > 2) ? $clog2(PLANE_HEIGHT) : 1;

  ssp_pkg::back_state_t state;
  ssp_pkg::back_state_t state_next;

  logic [8:0]  column_pos;
  logic [8:0]  column_pos_next;
  logic [8:0]  columns_left;
  logic [8:0]  columns_left_next;
  logic [16:0] bytes_left;
  logic [16:0] bytes_left_next;
  logic [16:0] byte_offset;
  logic [16:0] byte_offset_next;
  logic        in_repeat;
  logic        in_repeat_next;
  logic [15:0] repeat_len;
  logic [15:0] repeat_len_next;
  logic [6:0]  scaled_volume;
  logic [6:0]  scaled_volume_next;
  logic        channel_active;
  logic        channel_active_next;
  ssp_pkg::res_t dispatch_res;

  logic signed [15:0] p1;
  logic signed [22:0] p2;
  logic signed [22:0] p2_adj;
  logic signed [9:0]  q_row;
  logic signed [10:0] row_s;
  logic [ROW_W-1:0]   row_sat;
  logic [ROW_W-1:0]   row;
  logic [8:0]         pix_col;
  logic               pix_ok;
  logic               rd_ok;

  logic [7:0]    plane [DEPTH];
  logic [7:0]    rd_data;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_mask;
  logic          wr_val;
  logic [AW-1:0] clr_addr;
  logic          clr_last;

  logic          out_load;
  ssp_pkg::res_t out_next;

  assign clr_last = (clr_addr == AW'(DEPTH - 1));
  assign rd_addr  = AW'(head.read_index);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ssp_pkg::B_IDLE: begin
        if (pop) begin
          case (head.kind)
            ssp_pkg::ACT_PLOT: begin
              state_next = channel_active ? ssp_pkg::B_MUL2 : ssp_pkg::B_IDLE;
            end
            ssp_pkg::ACT_CLEAR: state_next = ssp_pkg::B_CLEAR;
            ssp_pkg::ACT_READ:  state_next = ssp_pkg::B_READ;
            default:            state_next = ssp_pkg::B_IDLE;
          endcase
        end
      end
      ssp_pkg::B_MUL2:  state_next = ssp_pkg::B_ROW;
      ssp_pkg::B_ROW:   state_next = ssp_pkg::B_WRITE;
      ssp_pkg::B_WRITE: state_next = ssp_pkg::B_IDLE;
      ssp_pkg::B_CLEAR: state_next = clr_last ? ssp_pkg::B_IDLE : ssp_pkg::B_CLEAR;
      ssp_pkg::B_READ:  state_next = ssp_pkg::B_IDLE;
      default:          state_next = ssp_pkg::B_IDLE;
    endcase
  end

  // FSM outputs.
  always_comb begin
    pop      = 1'b0;
    out_load = 1'b0;
    out_next = dispatch_res;
    wr_en    = 1'b0;
    wr_addr  = clr_addr;
    wr_mask  = 8'hFF;
    wr_val   = 1'b0;
    case (state)
      ssp_pkg::B_IDLE: begin
        pop      = q_valid && (!out_valid || out_ready);
        out_load = pop && (head.kind != ssp_pkg::ACT_READ);
      end
      ssp_pkg::B_WRITE: begin
        wr_en   = pix_ok;
        wr_addr = AW'(int'(row) * ROW_BYTES + int'(pix_col[8:3]));
        wr_mask = 8'h80 >> pix_col[2:0];
        wr_val  = 1'b1;
      end
      ssp_pkg::B_CLEAR: begin
        wr_en = 1'b1;
      end
      ssp_pkg::B_READ: begin
        out_load           = 1'b1;
        out_next           = '0;
        out_next.read_data = rd_ok ? rd_data : 8'd0;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // Channel bookkeeping for the command at the queue head.
  always_comb begin
    column_pos_next     = column_pos;
    columns_left_next   = columns_left;
    bytes_left_next     = bytes_left;
    byte_offset_next    = byte_offset;
    in_repeat_next      = in_repeat;
    repeat_len_next     = repeat_len;
    scaled_volume_next  = scaled_volume;
    channel_active_next = channel_active;
    dispatch_res        = '0;
    case (head.kind)
      ssp_pkg::ACT_BEGIN: begin
        scaled_volume_next  = head.scaled_volume;
        channel_active_next = 1'b0;
        if (head.short_sample) begin
          dispatch_res.status = ssp_pkg::ST_STOPPED;
        end else begin
          column_pos_next   = head.x_start;
          columns_left_next = head.column_count;
          bytes_left_next   = {head.sample_words, 1'b0};
          byte_offset_next  = '0;
          in_repeat_next    = 1'b0;
          repeat_len_next   = head.repeat_words;
          if (head.column_count == '0) begin
            dispatch_res.status = ssp_pkg::ST_DONE;
          end else begin
            channel_active_next = 1'b1;
          end
        end
      end
      ssp_pkg::ACT_PLOT: begin
        if (!channel_active) begin
          dispatch_res.status = ssp_pkg::ST_STOPPED;
        end else begin
          byte_offset_next  = byte_offset + 1'b1;
          bytes_left_next   = bytes_left - 1'b1;
          column_pos_next   = column_pos + 1'b1;
          columns_left_next = columns_left - 1'b1;
          if (bytes_left_next == '0) begin
            if (repeat_len < 16'd2) begin
              dispatch_res.status = ssp_pkg::ST_STOPPED;
              channel_active_next = 1'b0;
            end else begin
              in_repeat_next   = 1'b1;
              byte_offset_next = '0;
              bytes_left_next  = {repeat_len, 1'b0};
            end
          end
          if (dispatch_res.status == ssp_pkg::ST_CONTINUE && columns_left_next == '0) begin
            dispatch_res.status = ssp_pkg::ST_DONE;
            channel_active_next = 1'b0;
          end
          if (dispatch_res.status == ssp_pkg::ST_CONTINUE) begin
            dispatch_res.next_offset  = byte_offset_next;
            dispatch_res.next_in_loop = in_repeat_next;
          end
        end
      end
      default: begin
        dispatch_res = '0;
      end
    endcase
  end

  // Scaling datapath; the quotient truncates toward zero.
  always_comb begin
    p2_adj = p2[22] ? (p2 + 23'sd8191) : p2;
    q_row  = p2_adj[22:13];
    row_s  = {q_row[9], q_row} + 11'(PLANE_HEIGHT / 2);
    if (row_s[10]) begin
      row_sat = '0;
    end else if (row_s > $signed(11'(PLANE_HEIGHT - 1))) begin
      row_sat = ROW_W'(PLANE_HEIGHT - 1);
    end else begin
      row_sat = ROW_W'(row_s);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ssp_pkg::B_CLEAR;
      boot           <= 1'b1;
      clr_addr       <= '0;
      out_valid      <= 1'b0;
      column_pos     <= '0;
      columns_left   <= '0;
      bytes_left     <= '0;
      byte_offset    <= '0;
      in_repeat      <= 1'b0;
      repeat_len     <= '0;
      scaled_volume  <= '0;
      channel_active <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ssp_pkg::B_CLEAR) begin
        clr_addr <= clr_last ? '0 : clr_addr + 1'b1;
        if (clr_last) begin
          boot <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        column_pos     <= column_pos_next;
        columns_left   <= columns_left_next;
        bytes_left     <= bytes_left_next;
        byte_offset    <= byte_offset_next;
        in_repeat      <= in_repeat_next;
        repeat_len     <= repeat_len_next;
        scaled_volume  <= scaled_volume_next;
        channel_active <= channel_active_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= out_next;
    end
    if (pop) begin
      p1      <= head.sample_value * $signed({1'b0, scaled_volume});
      pix_col <= column_pos;
      pix_ok  <= (int'(column_pos) < PLANE_WIDTH);
      rd_ok   <= (int'(head.read_index) < DEPTH);
    end
    if (state == ssp_pkg::B_MUL2) begin
      p2 <= p1 * $signed({1'b0, scope_height});
    end
    if (state == ssp_pkg::B_ROW) begin
      row <= row_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      for (int i = 0; i < 8; i++) begin
        if (wr_mask[i]) begin
          plane[wr_addr][i] <= wr_val;
        end
      end
    end
    rd_data <= plane[rd_addr];
  end

  `SSP_ASSERT_NOW(a_pop_out_free, clk, rst, pop, (!out_valid || out_ready), "dispatch with result register busy")
  `SSP_ASSERT_NEXT(a_read_follows, clk, rst, (pop && head.kind == ssp_pkg::ACT_READ), (state == ssp_pkg::B_READ), "read dispatch did not reach read state")
  `SSP_ASSERT_NOW(a_pixel_onehot, clk, rst, (wr_en && state == ssp_pkg::B_WRITE), $onehot(wr_mask), "pixel write touches more than one bit")
  `SSP_ASSERT_NOW(a_active_counts, clk, rst, channel_active, (columns_left != '0 && bytes_left != '0), "active channel with nothing left")

endmodule

`default_nettype wire

FILE: test/sample_scope_plotter_tb.sv
// Self-checking testbench for the sample scope plotter: stream stimulus, scoreboard, checks.
`timescale 1ns / 100ps

module testbench;

  localparam int WIDTH_PX     = 320;
  localparam int HEIGHT_PX    = 64;
  localparam int ROW_BYTES    = (WIDTH_PX + 7) / 8;
  localparam int PLANE_BYTES  = ROW_BYTES * HEIGHT_PX;
  localparam int LIMIT_CYCLES = 600000;
  localparam int SETTLE       = 8;
  localparam int PHASE_WORDS  = 75;
  localparam int NUM_PHASES   = 6;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        loop;
    logic [16:0] offset;
    logic [1:0]  status;
  } scope_result_t;

  class plot_scoreboard;
    logic [7:0]    plane [PLANE_BYTES];
    logic [8:0]    col_pos;
    logic [8:0]    cols_left;
    logic [16:0]   bytes_left;
    logic [16:0]   offset;
    logic          looping;
    logic [15:0]   rep_len;
    logic [6:0]    svol;
    logic          active;
    logic [6:0]    main_vol;
    logic [5:0]    height;
    scope_result_t results_due [$];
    int failures, begins, plots, wraps, stops, reads, hits, clears, reg_writes;

    function new();
      foreach (plane[i]) plane[i] = 8'h00;
      col_pos = 0; cols_left = 0; bytes_left = 0; offset = 0; looping = 0;
      rep_len = 0; svol = 0; active = 0; main_vol = 7'd64; height = 6'd32;
      failures = 0; begins = 0; plots = 0; wraps = 0; stops = 0;
      reads = 0; hits = 0; clears = 0; reg_writes = 0;
    endfunction

    function void write_reg(logic idx, logic [6:0] val);
      reg_writes++;
      if (idx == ssp_pkg::REG_MAIN_VOLUME) main_vol = val;
      else height = val[5:0];
    endfunction

    function void draw_pixel(logic [8:0] col, logic [7:0] raw);
      int s, sv, h, q, pix_row, idx;
      s = int'($signed(raw));
      sv = int'(svol);
      h = int'(height);
      q = (s * sv * h) / 8192;
      pix_row = q + HEIGHT_PX / 2;
      if (pix_row < 0) pix_row = 0;
      if (pix_row > HEIGHT_PX - 1) pix_row = HEIGHT_PX - 1;
      if (col >= WIDTH_PX) return;
      idx = pix_row * ROW_BYTES + int'(col >> 3);
      plane[idx] = plane[idx] | (8'h80 >> col[2:0]);
    endfunction

    function void note_word(ssp_pkg::action_t act, logic [ssp_pkg::IN_DATA_W-1:0] d);
      scope_result_t r;
      int v;
      r = '0;
      case (act)
        ssp_pkg::ACT_BEGIN: begin
          begins++;
          v = (int'(d[24:18]) * int'(main_vol)) >> 6;
          svol = (v > 127) ? 7'd127 : v[6:0];
          active = 0;
          if (d[40:25] < 2) begin
            r.status = ssp_pkg::ST_STOPPED;
          end else begin
            col_pos = d[8:0];
            cols_left = d[17:9];
            bytes_left = {d[40:25], 1'b0};
            offset = 0;
            looping = 0;
            rep_len = d[56:41];
            if (cols_left == 0) r.status = ssp_pkg::ST_DONE;
            else active = 1;
          end
        end
        ssp_pkg::ACT_PLOT: begin
          if (!active) begin
            r.status = ssp_pkg::ST_STOPPED;
          end else begin
            plots++;
            draw_pixel(col_pos, d[64:57]);
            offset++;
            bytes_left--;
            col_pos++;
            cols_left--;
            if (bytes_left == 0) begin
              if (rep_len < 2) begin
                r.status = ssp_pkg::ST_STOPPED;
                active = 0;
                stops++;
              end else begin
                looping = 1;
                offset = 0;
                bytes_left = {rep_len, 1'b0};
                wraps++;
              end
            end
            if (r.status == ssp_pkg::ST_CONTINUE && cols_left == 0) begin
              r.status = ssp_pkg::ST_DONE;
              active = 0;
            end
            if (r.status == ssp_pkg::ST_CONTINUE) begin
              r.offset = offset;
              r.loop = looping;
            end
          end
        end
        ssp_pkg::ACT_CLEAR: begin
          clears++;
          foreach (plane[i]) plane[i] = 8'h00;
        end
        default: begin
          reads++;
          if (d[76:65] < PLANE_BYTES) r.rdata = plane[d[76:65]];
          if (r.rdata != 0) hits++;
        end
      endcase
      results_due.push_back(r);
    endfunction

    function void check_word(logic [ssp_pkg::OUT_DATA_W-1:0] d);
      scope_result_t want, got;
      got = d[27:0];
      if (results_due.size() == 0) begin
        failures++;
        if (failures <= 10) $display("Unexpected result word %h with nothing pending", d);
        return;
      end
      want = results_due.pop_front();
      if (got.status !== want.status || got.offset !== want.offset ||
          got.loop !== want.loop || got.rdata !== want.rdata) begin
        failures++;
        if (failures <= 10)
          $display("Mismatch: status %0d/%0d offset %0d/%0d loop %0d/%0d data %h/%h (exp/act)",
                   want.status, got.status, want.offset, got.offset,
                   want.loop, got.loop, want.rdata, got.rdata);
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [ssp_pkg::IN_DATA_W-1:0]  s_tdata;
  logic [ssp_pkg::IN_USER_W-1:0]  s_tuser;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [ssp_pkg::OUT_DATA_W-1:0] m_tdata;
  logic                           cfg_we;
  logic                           cfg_index;
  logic [6:0]                     cfg_data;

  plot_scoreboard sb = new();
  int tx_idle_pct = 16;
  int rx_idle_pct = 16;
  int rx_hold = 0;
  int words_sent = 0;
  int cycle_count = 0;

  sample_scope_plotter #(.PLANE_WIDTH(WIDTH_PX), .PLANE_HEIGHT(HEIGHT_PX)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    if (cfg_we) sb.write_reg(cfg_index, cfg_data);
    if (!rst && s_tvalid && s_tready) sb.note_word(ssp_pkg::action_t'(s_tuser), s_tdata);
    if (!rst && m_tvalid && m_tready) sb.check_word(m_tdata);
  end

  initial begin
    m_tready = 0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        m_tready = 0;
        rx_hold--;
      end else begin
        m_tready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) @(posedge clk) cycle_count++;
    $display("Timed out after %0d cycles", cycle_count);
    $display("FAIL sample_scope_plotter");
    $finish;
  end

  function automatic logic [ssp_pkg::IN_DATA_W-1:0] pack_fields(
      logic [8:0] x, logic [8:0] cols, logic [6:0] vol, logic [15:0] words,
      logic [15:0] rep, logic [7:0] sval, logic [11:0] ridx);
    return {3'b000, ridx, sval, rep, words, vol, cols, x};
  endfunction

  task automatic send_word(ssp_pkg::action_t act, logic [ssp_pkg::IN_DATA_W-1:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid = 0;
      @(negedge clk);
    end
    s_tvalid = 1;
    s_tuser = act;
    s_tdata = d;
    do @(posedge clk); while (!s_tready);
    words_sent++;
    @(negedge clk);
    s_tvalid = 0;
  endtask

  task automatic send_begin(logic [8:0] x, logic [8:0] cols, logic [6:0] vol,
                            logic [15:0] words, logic [15:0] rep);
    send_word(ssp_pkg::ACT_BEGIN, pack_fields(x, cols, vol, words, rep, 8'h00, 12'h000));
  endtask

  task automatic send_plot(logic [7:0] sval);
    send_word(ssp_pkg::ACT_PLOT,
              pack_fields(9'd0, 9'd0, 7'd0, 16'd0, 16'd0, sval, 12'h000));
  endtask

  task automatic send_read(logic [11:0] ridx);
    send_word(ssp_pkg::ACT_READ,
              pack_fields(9'd0, 9'd0, 7'd0, 16'd0, 16'd0, 8'h00, ridx));
  endtask

  task automatic wait_drained();
    while (sb.results_due.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic set_reg(logic idx, logic [6:0] val);
    cfg_we = 1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 0;
  endtask

  task automatic random_trace();
    logic [8:0]  x, cols;
    logic [6:0]  vol;
    logic [15:0] words, rep;
    int r, n;
    x = ($urandom_range(9) == 0) ? 9'($urandom_range(511, 300)) : 9'($urandom_range(319));
    r = $urandom_range(99);
    cols = (r < 8) ? 9'd0 : (r < 80) ? 9'($urandom_range(40, 1)) : 9'($urandom_range(511));
    vol = ($urandom_range(4) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(64));
    r = $urandom_range(99);
    words = (r < 8) ? 16'($urandom_range(1)) :
            (r < 92) ? 16'($urandom_range(12, 2)) : 16'($urandom);
    r = $urandom_range(99);
    rep = (r < 40) ? 16'($urandom_range(1)) :
          (r < 90) ? 16'($urandom_range(8, 2)) : 16'($urandom);
    send_begin(x, cols, vol, words, rep);
    n = ((cols > 48) ? 48 : int'(cols)) + int'($urandom_range(2));
    repeat (n) send_plot(8'($urandom_range(255)));
  endtask

  task automatic random_phase(int quota);
    int goal, r;
    goal = words_sent + quota;
    while (words_sent < goal) begin
      r = $urandom_range(99);
      if (r < 70) begin
        random_trace();
      end else if (r < 85) begin
        repeat ($urandom_range(4, 1)) begin
          case ($urandom_range(3))
            0: send_read(12'($urandom_range(4095, PLANE_BYTES)));
            1: send_read(12'($urandom_range(PLANE_BYTES - 1)));
            default: send_read(12'($urandom_range(44 * ROW_BYTES, 20 * ROW_BYTES)));
          endcase
        end
      end else if (r < 88) begin
        send_word(ssp_pkg::ACT_CLEAR, '0);
      end else begin
        send_word(ssp_pkg::action_t'(2'($urandom_range(3))),
                  {3'b000, 13'($urandom), 32'($urandom), 32'($urandom)});
      end
    end
  endtask

  logic [6:0] vol_settings [NUM_PHASES];
  logic [6:0] height_settings [NUM_PHASES];

  initial begin
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = ssp_pkg::ACT_BEGIN;
    cfg_we = 0;
    cfg_index = ssp_pkg::REG_MAIN_VOLUME;
    cfg_data = '0;
    vol_settings = '{7'd127, 7'd64, 7'd0, 7'($urandom_range(127)), 7'd96, 7'd64};
    height_settings = '{7'd63, 7'd32, 7'd0, 7'($urandom_range(63)), 7'd1, 7'd16};
    repeat (6) @(negedge clk);
    rst = 0;

    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_drained();
      set_reg(ssp_pkg::REG_MAIN_VOLUME, vol_settings[p]);
      set_reg(ssp_pkg::REG_SCOPE_HEIGHT, height_settings[p]);

      if (p == 0) begin
        // Idle plot, short samples and a begin with no columns.
        send_plot(8'h00);
        send_begin(9'd10, 9'd5, 7'd64, 16'd0, 16'd4);
        send_begin(9'd10, 9'd5, 7'd64, 16'd1, 16'd4);
        send_begin(9'd10, 9'd0, 7'd64, 16'd5, 16'd4);
        // Saturated volume, rows clipped at both ends, columns past the right
        // edge, and the sample ending on the last column with no repeat.
        send_begin(9'd318, 9'd4, 7'd127, 16'd2, 16'd0);
        send_plot(8'h7f);
        send_plot(8'h80);
        send_plot(8'h01);
        send_plot(8'hff);
        // Wrap into the repeat region before the columns run out.
        send_begin(9'd0, 9'd6, 7'd64, 16'd2, 16'd2);
        repeat (6) send_plot(8'($urandom_range(255)));
        send_begin(9'd511, 9'd511, 7'd0, 16'hffff, 16'hffff);
        send_plot(8'h55);
        send_begin(9'd100, 9'd2, 7'd1, 16'd2, 16'd0);
        send_plot(8'h80);
        send_plot(8'h7f);
        send_read(12'(PLANE_BYTES - 1));
        send_read(12'd39);
        send_read(12'hfff);
        send_read(12'(PLANE_BYTES));
        send_word(ssp_pkg::ACT_CLEAR, '0);
        send_read(12'(PLANE_BYTES - 1));
      end

      if (p == 1) begin
        // Hold the result side off long enough for the input to back up.
        tx_idle_pct = 0;
        rx_hold = 100;
        send_begin(9'd40, 9'd30, 7'd64, 16'd6, 16'd3);
        repeat (20) send_plot(8'($urandom_range(255)));
        tx_idle_pct = 16;
        wait_drained();
      end

      if (p == 3) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      random_phase(PHASE_WORDS);
      tx_idle_pct = 16;
      rx_idle_pct = 16;
    end

    wait_drained();
    $display("Sent %0d words: %0d begins, %0d plots, %0d wraps, %0d stops, %0d clears",
             words_sent, sb.begins, sb.plots, sb.wraps, sb.stops, sb.clears);
    $display("Read %0d plane bytes (%0d nonzero) over %0d register writes, %0d failures",
             sb.reads, sb.hits, sb.reg_writes, sb.failures);
    if (sb.failures == 0 && sb.results_due.size() == 0) begin
      $display("PASS sample_scope_plotter");
    end else begin
      $display("FAIL sample_scope_plotter");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl
rtl/ssp_pkg.sv
rtl/ssp_front.sv
rtl/ssp_queue.sv
rtl/ssp_back.sv
rtl/sample_scope_plotter.sv
test/sample_scope_plotter_tb.sv
